>>> design/fbpa_pkg.sv
// ---------------------------------------------------------------------------
// fbpa_pkg: shared constants for the fixed block pool allocator
// Field widths, default pool geometry, command kinds and status codes.
// ---------------------------------------------------------------------------
package fbpa_pkg;

  // Pool geometry defaults
  localparam int FBPA_BLOCK_BYTES = 64;
  localparam int FBPA_NUM_BLOCKS  = 16;

  // Port field widths
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int NUMBER_W = 4;
  localparam int COUNT_W  = 5;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command kinds handed from front to back
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NULL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Occupancy of a queue as seen by its producer and consumer
  typedef struct packed {
    logic full;
    logic not_empty;
  } fbpa_qstat_t;

endpackage

>>> design/fbpa_ram.sv
// ---------------------------------------------------------------------------
// fbpa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/fbpa_front.sv
// ---------------------------------------------------------------------------
// fbpa_front: request intake and classification
// Takes requests, works out the pool offset and block index of a free
// request, checks null, range and alignment, and emits one command per item.
// ---------------------------------------------------------------------------
module fbpa_front #(
  parameter int BLOCK_BYTES = fbpa_pkg::FBPA_BLOCK_BYTES,
  parameter int NUM_BLOCKS  = fbpa_pkg::FBPA_NUM_BLOCKS,
  parameter int IDX_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fbpa_pkg::ADDR_W-1:0] pool_base,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [fbpa_pkg::ADDR_W-1:0] in_free_address,
  output logic                        cmd_valid,
  output logic [fbpa_pkg::KIND_W-1:0] cmd_kind,
  output logic [IDX_W-1:0]            cmd_idx,
  input  fbpa_pkg::fbpa_qstat_t       q_stat
);

  import fbpa_pkg::*;

  localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int OFF_W      = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int BB_LOG     = $clog2(BLOCK_BYTES);
  localparam int SH         = OFF_W + BB_LOG;
  // Reciprocal of the block size, exact for every offset below 2^OFF_W
  localparam logic [63:0] RECIP64 =
      ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [OFF_W:0] RECIP = RECIP64[OFF_W:0];
  localparam int PROD_W = 2 * OFF_W + 1;

  logic [ADDR_W-1:0] offset;
  logic              s1_ready;
  logic              s2_ready;
  logic              accept;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_op_r, s1_null_r, s1_range_r;
  logic [OFF_W-1:0]  s1_off_r;

  logic              s2_v_r, s2_v_nxt;
  logic              s2_op_r, s2_null_r, s2_range_r;
  logic [OFF_W-1:0]  s2_off_r;
  logic [IDX_W-1:0]  s2_idx_r;

  logic [PROD_W-1:0] prod;
  logic [OFF_W-1:0]  back_off;
  logic              aligned;

  assign s2_ready = !s2_v_r || !q_stat.full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;

  assign offset = in_free_address - pool_base;
  assign prod   = PROD_W'(s1_off_r) * PROD_W'(RECIP);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_opcode;
      s1_null_r  <= (in_free_address == '0);
      s1_range_r <= (offset < ADDR_W'(POOL_BYTES));
      s1_off_r   <= offset[OFF_W-1:0];
    end
    if (s2_ready && s1_v_r) begin
      s2_op_r    <= s1_op_r;
      s2_null_r  <= s1_null_r;
      s2_range_r <= s1_range_r;
      s2_off_r   <= s1_off_r;
      s2_idx_r   <= IDX_W'(prod >> SH);
    end
  end

  // An offset is aligned when the index scaled back gives it exactly
  assign back_off = OFF_W'(OFF_W'(s2_idx_r) * OFF_W'(BLOCK_BYTES));
  assign aligned  = (back_off == s2_off_r);

  always_comb begin
    if (!s2_op_r) begin
      cmd_kind = KIND_ALLOC;
    end else if (s2_null_r) begin
      cmd_kind = KIND_NULL;
    end else if (!s2_range_r || !aligned) begin
      cmd_kind = KIND_BAD;
    end else begin
      cmd_kind = KIND_FREE;
    end
  end

  assign cmd_valid = s2_v_r;
  assign cmd_idx   = s2_idx_r;

endmodule

>>> design/fbpa_fifo.sv
// ---------------------------------------------------------------------------
// fbpa_fifo: short command queue between front and back
// Register-based ring; push when not full, pop when not empty.
// ---------------------------------------------------------------------------
module fbpa_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = fbpa_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_W-1:0]     push_data,
  input  logic                  pop,
  output logic [DATA_W-1:0]     pop_data,
  output fbpa_pkg::fbpa_qstat_t stat
);

  import fbpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full      = (count_r == CNT_W'(DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign pop_data       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/fbpa_back.sv
// ---------------------------------------------------------------------------
// fbpa_back: free-index stack and result formation
// Pops or pushes the stack in RAM, keeps the free and in-use counts,
// and builds the result item in an output register.
// ---------------------------------------------------------------------------
module fbpa_back #(
  parameter int BLOCK_BYTES = fbpa_pkg::FBPA_BLOCK_BYTES,
  parameter int NUM_BLOCKS  = fbpa_pkg::FBPA_NUM_BLOCKS,
  parameter int IDX_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fbpa_pkg::ADDR_W-1:0]   pool_base,
  input  logic                          cmd_valid,
  input  logic [fbpa_pkg::KIND_W-1:0]   cmd_kind,
  input  logic [IDX_W-1:0]              cmd_idx,
  output logic                          cmd_take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0] out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [fbpa_pkg::NUMBER_W-1:0] out_block_number,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_blocks_in_use,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_blocks_free
);

  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] NUM_C = CNT_W'(NUM_BLOCKS);

  // Stack state; low_r is the lowest depth reached since reset; entries
  // below it were never written and stand for index i (entry i)
  logic [CNT_W-1:0]    fe_r, fe_nxt;
  logic [CNT_W-1:0]    use_r, use_nxt;
  logic [CNT_W-1:0]    low_r, low_nxt;
  logic [CNT_W-1:0]    pos_pop;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_rdata;

  logic                adv_out;
  logic                b_ready;

  logic                b_v_r, b_v_nxt;
  logic [STATUS_W-1:0] b_status_r, b_status_nxt;
  logic                b_pop_r, b_pop_nxt;
  logic                b_ram_r, b_ram_nxt;
  logic [IDX_W-1:0]    b_idx_r, b_idx_nxt;
  logic [CNT_W-1:0]    b_use_r;
  logic [CNT_W-1:0]    b_fe_r;

  logic [IDX_W-1:0]    fin_idx;
  logic [ADDR_W-1:0]   fin_addr;
  logic [IDX_W+NUMBER_W-1:0] num_wide;
  logic [CNT_W+COUNT_W-1:0]  use_wide;
  logic [CNT_W+COUNT_W-1:0]  fe_wide;

  logic                out_v_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [NUMBER_W-1:0] out_num_r;
  logic [COUNT_W-1:0]  out_use_r;
  logic [COUNT_W-1:0]  out_fe_r;

  assign adv_out  = !out_v_r || !out_stall;
  assign b_ready  = !b_v_r || adv_out;
  assign cmd_take = cmd_valid && b_ready;
  assign pos_pop  = fe_r - 1'b1;

  always_comb begin
    fe_nxt       = fe_r;
    use_nxt      = use_r;
    low_nxt      = low_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = fe_r[IDX_W-1:0];
    b_status_nxt = b_status_r;
    b_pop_nxt    = b_pop_r;
    b_ram_nxt    = b_ram_r;
    b_idx_nxt    = b_idx_r;
    if (cmd_take) begin
      b_pop_nxt = 1'b0;
      b_ram_nxt = 1'b0;
      b_idx_nxt = '0;
      case (cmd_kind)
        KIND_ALLOC: begin
          if (fe_r == '0) begin
            b_status_nxt = ST_EXHAUSTED;
          end else begin
            b_status_nxt = ST_OK;
            ram_re       = 1'b1;
            fe_nxt       = pos_pop;
            use_nxt      = use_r + 1'b1;
            low_nxt      = (pos_pop < low_r) ? pos_pop : low_r;
            b_pop_nxt    = 1'b1;
            b_ram_nxt    = (pos_pop >= low_r);
            b_idx_nxt    = pos_pop[IDX_W-1:0];
          end
        end
        KIND_FREE: begin
          b_idx_nxt = cmd_idx;
          if (fe_r >= NUM_C) begin
            b_status_nxt = ST_FULL;
          end else begin
            b_status_nxt = ST_OK;
            ram_we       = 1'b1;
            fe_nxt       = fe_r + 1'b1;
            use_nxt      = (use_r != '0) ? use_r - 1'b1 : use_r;
          end
        end
        KIND_NULL: begin
          b_status_nxt = ST_NULL;
        end
        default: begin
          b_status_nxt = ST_INVALID;
        end
      endcase
    end
    b_v_nxt = b_v_r;
    if (cmd_take) begin
      b_v_nxt = 1'b1;
    end else if (adv_out) begin
      b_v_nxt = 1'b0;
    end
  end

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BLOCKS),
    .AW    (IDX_W)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd_idx),
    .re    (ram_re),
    .raddr (pos_pop[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Popped index comes from RAM only where that depth was written since reset
  assign fin_idx  = (b_pop_r && b_ram_r) ? ram_rdata : b_idx_r;
  assign fin_addr = b_pop_r ?
      pool_base + ADDR_W'(ADDR_W'(fin_idx) * ADDR_W'(BLOCK_BYTES)) : '0;
  assign num_wide = {{NUMBER_W{1'b0}}, fin_idx};
  assign use_wide = {{COUNT_W{1'b0}}, b_use_r};
  assign fe_wide  = {{COUNT_W{1'b0}}, b_fe_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r    <= NUM_C;
      use_r   <= '0;
      low_r   <= NUM_C;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      fe_r  <= fe_nxt;
      use_r <= use_nxt;
      low_r <= low_nxt;
      b_v_r <= b_v_nxt;
      if (adv_out) begin
        out_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_status_r <= b_status_nxt;
    b_pop_r    <= b_pop_nxt;
    b_ram_r    <= b_ram_nxt;
    b_idx_r    <= b_idx_nxt;
    if (cmd_take) begin
      b_use_r <= use_nxt;
      b_fe_r  <= fe_nxt;
    end
    if (adv_out && b_v_r) begin
      out_status_r <= b_status_r;
      out_addr_r   <= fin_addr;
      out_num_r    <= num_wide[NUMBER_W-1:0];
      out_use_r    <= use_wide[COUNT_W-1:0];
      out_fe_r     <= fe_wide[COUNT_W-1:0];
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_number  = out_num_r;
  assign out_blocks_in_use = out_use_r;
  assign out_blocks_free   = out_fe_r;

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
      (CNT_W + 1)'(fe_r) + (CNT_W + 1)'(use_r) <= (CNT_W + 1)'(NUM_BLOCKS))
    else $error("free plus in-use count exceeds pool size");

  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
      low_r <= fe_r)
    else $error("low mark above stack depth");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
      out_v_r && out_stall |=> out_v_r)
    else $error("stalled result dropped");

endmodule

>>> design/fixed_block_pool_allocator_top.sv
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_top: fixed-size block pool allocator
// LIFO stack of free block indices; allocate pops, free checks and pushes.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   cfg     | cfg_wr_en, cfg_wr_data (pool base address)     | in
//   in      | in_valid/in_stall, in_opcode, in_free_address  | in
//   out     | out_valid/out_stall, status, address, counts   | out
//
// One item per cycle sustained while neither side stalls; an item runs from
// accept to result through two front stages (offset, reciprocal multiply),
// the queue, the stack RAM access and the output register.
// Synchronous active-low reset: stack full, nothing in use, base zero.
// No clearing pass: untouched stack entries are tracked by a low mark.
// Either side may stall; a two-entry queue decouples front from back.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_top #(
  parameter int BLOCK_BYTES = fbpa_pkg::FBPA_BLOCK_BYTES,
  parameter int NUM_BLOCKS  = fbpa_pkg::FBPA_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [fbpa_pkg::ADDR_W-1:0]   in_free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0] out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_block_address,
  output logic [fbpa_pkg::NUMBER_W-1:0] out_block_number,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_blocks_in_use,
  output logic [fbpa_pkg::COUNT_W-1:0]  out_blocks_free
);

  import fbpa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CMD_W = KIND_W + IDX_W;

  logic [ADDR_W-1:0] pool_base_r;
  logic              f_valid;
  logic [KIND_W-1:0] f_kind;
  logic [IDX_W-1:0]  f_idx;
  fbpa_qstat_t       q_stat;
  logic [CMD_W-1:0]  q_data;
  logic              b_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (cfg_wr_en) begin
      pool_base_r <= cfg_wr_data;
    end
  end

  fbpa_front #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .pool_base       (pool_base_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_free_address (in_free_address),
    .cmd_valid       (f_valid),
    .cmd_kind        (f_kind),
    .cmd_idx         (f_idx),
    .q_stat          (q_stat)
  );

  fbpa_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_kind, f_idx}),
    .pop       (b_take),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  fbpa_back #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pool_base         (pool_base_r),
    .cmd_valid         (q_stat.not_empty),
    .cmd_kind          (q_data[CMD_W-1:IDX_W]),
    .cmd_idx           (q_data[IDX_W-1:0]),
    .cmd_take          (b_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_number  (out_block_number),
    .out_blocks_in_use (out_blocks_in_use),
    .out_blocks_free   (out_blocks_free)
  );

endmodule
